/* design/mtx_inv_pkg.sv */
package mtx_inv_pkg;

    localparam int DW      = 32;
    localparam int FB      = 16;
    localparam int NL      = 9;
    localparam int THR_W   = DW - 1;
    localparam int SH      = 2 * FB;
    localparam int PW      = 2 * DW;
    localparam int CW      = 2 * DW + 1;
    localparam int DPW     = 2 * DW + 1;
    localparam int DETW    = DW + CW + 2;
    localparam int MAGW    = DETW;
    localparam int NUMW    = 2 * DW + SH;
    localparam int QW      = DW;
    localparam int DIVW    = MAGW + QW;
    localparam int FRONT_ST = 6;
    localparam int DIV_ST  = QW + 1;
    localparam int NSTG    = FRONT_ST + DIV_ST + 1;

    // element indices of the two products of each cofactor: x*y - z*v
    localparam int MX [NL][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

endpackage

/* design/mtx_inv_in_if.sv */
interface mtx_inv_in_if;
    import mtx_inv_pkg::*;

    logic valid;
    logic ready;
    logic signed [DW-1:0] a00;
    logic signed [DW-1:0] a01;
    logic signed [DW-1:0] a02;
    logic signed [DW-1:0] a10;
    logic signed [DW-1:0] a11;
    logic signed [DW-1:0] a12;
    logic signed [DW-1:0] a20;
    logic signed [DW-1:0] a21;
    logic signed [DW-1:0] a22;

    modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    input ready);
    modport sink (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  output ready);
endinterface

/* design/mtx_inv_out_if.sv */
interface mtx_inv_out_if;
    import mtx_inv_pkg::*;

    logic valid;
    logic ready;
    logic signed [DW-1:0] b00;
    logic signed [DW-1:0] b01;
    logic signed [DW-1:0] b02;
    logic signed [DW-1:0] b10;
    logic signed [DW-1:0] b11;
    logic signed [DW-1:0] b12;
    logic signed [DW-1:0] b20;
    logic signed [DW-1:0] b21;
    logic signed [DW-1:0] b22;
    logic invertible;

    modport source (output valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
                    invertible, input ready);
    modport sink (input valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
                  invertible, output ready);
endinterface

/* design/mtx_inv_front.sv */
module mtx_inv_front (
    input  logic                                   clk,
    input  logic [mtx_inv_pkg::FRONT_ST-1:0]       en,
    input  logic signed [mtx_inv_pkg::DW-1:0]      a [mtx_inv_pkg::NL],
    input  logic [mtx_inv_pkg::THR_W-1:0]          thr,
    output logic [mtx_inv_pkg::MAGW-1:0]           mag,
    output logic                                   sing,
    output logic [mtx_inv_pkg::NUMW-1:0]           num [mtx_inv_pkg::NL],
    output logic                                   neg [mtx_inv_pkg::NL]
);
    import mtx_inv_pkg::*;

    logic signed [PW-1:0]   p0_reg [NL][2];
    logic signed [DW-1:0]   a0_reg [3];
    logic signed [DW-1:0]   a1_reg [3];
    logic signed [CW-1:0]   c1_reg [NL];
    logic signed [CW-1:0]   c2_reg [NL];
    logic signed [CW-1:0]   c3_reg [NL];
    logic signed [CW-1:0]   c4_reg [NL];
    logic signed [DPW-1:0]  pl2_reg [3];
    logic signed [DPW-1:0]  ph2_reg [3];
    logic [DETW-1:0]        prod3_reg [3];
    logic [DETW-1:0]        det4_reg;
    logic [MAGW-1:0]        thr_ext;

    // cofactor products
    for (genvar k = 0; k < NL; k++) begin : g_prod
        always_ff @(posedge clk) begin
            if (en[0]) begin
                p0_reg[k][0] <= a[MX[k][0]] * a[MX[k][1]];
                p0_reg[k][1] <= a[MX[k][2]] * a[MX[k][3]];
            end
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_row0
        always_ff @(posedge clk) begin
            if (en[0]) begin
                a0_reg[j] <= a[j];
            end
            if (en[1]) begin
                a1_reg[j] <= a0_reg[j];
            end
        end
    end

    // cofactors
    for (genvar k = 0; k < NL; k++) begin : g_cof
        always_ff @(posedge clk) begin
            if (en[1]) begin
                c1_reg[k] <= $signed({p0_reg[k][0][PW-1], p0_reg[k][0]})
                           - $signed({p0_reg[k][1][PW-1], p0_reg[k][1]});
            end
            if (en[2]) begin
                c2_reg[k] <= c1_reg[k];
            end
            if (en[3]) begin
                c3_reg[k] <= c2_reg[k];
            end
            if (en[4]) begin
                c4_reg[k] <= c3_reg[k];
            end
        end
    end

    // determinant partial products, cofactor split in low and high halves
    for (genvar j = 0; j < 3; j++) begin : g_det
        always_ff @(posedge clk) begin
            if (en[2]) begin
                pl2_reg[j] <= a1_reg[j] * $signed({1'b0, c1_reg[3*j][DW-1:0]});
                ph2_reg[j] <= a1_reg[j] * $signed(c1_reg[3*j][CW-1:DW]);
            end
            if (en[3]) begin
                prod3_reg[j] <= {{(DETW-DPW-DW){ph2_reg[j][DPW-1]}}, ph2_reg[j], {DW{1'b0}}}
                              + {{(DETW-DPW){pl2_reg[j][DPW-1]}}, pl2_reg[j]};
            end
        end
    end

    always_ff @(posedge clk) begin
        if (en[4]) begin
            det4_reg <= prod3_reg[0] + prod3_reg[1] + prod3_reg[2];
        end
    end

    assign thr_ext = {{(MAGW-THR_W-SH){1'b0}}, thr, {SH{1'b0}}};

    always_ff @(posedge clk) begin
        if (en[5]) begin
            mag  <= det4_reg[DETW-1] ? (~det4_reg + 1'b1) : det4_reg;
            sing <= (det4_reg == '0)
                 || ((det4_reg[DETW-1] ? (~det4_reg + 1'b1) : det4_reg) < thr_ext);
        end
    end

    for (genvar k = 0; k < NL; k++) begin : g_num
        logic [CW-1:0] cabs;
        assign cabs = c4_reg[k][CW-1] ? (~c4_reg[k] + 1'b1) : c4_reg[k];
        always_ff @(posedge clk) begin
            if (en[5]) begin
                num[k] <= {cabs[CW-2:0], {SH{1'b0}}};
                neg[k] <= c4_reg[k][CW-1] ^ det4_reg[DETW-1];
            end
        end
    end
endmodule

/* design/mtx_inv_div_lane.sv */
module mtx_inv_div_lane (
    input  logic                                 clk,
    input  logic [mtx_inv_pkg::DIV_ST-1:0]       en,
    input  logic [mtx_inv_pkg::NUMW-1:0]         num_in,
    input  logic                                 neg_in,
    input  logic [mtx_inv_pkg::MAGW-1:0]         mag_in [mtx_inv_pkg::DIV_ST],
    output logic [mtx_inv_pkg::QW-1:0]           q,
    output logic                                 big,
    output logic                                 neg
);
    import mtx_inv_pkg::*;

    logic [NUMW-1:0] rem_reg [DIV_ST];
    logic [QW-1:0]   q_reg   [DIV_ST];
    logic            big_reg [DIV_ST];
    logic            neg_reg [DIV_ST];

    // quotient of 2^QW or more saturates
    always_ff @(posedge clk) begin
        if (en[0]) begin
            rem_reg[0] <= num_in;
            q_reg[0]   <= '0;
            big_reg[0] <= {{(DIVW-NUMW){1'b0}}, num_in} >= {mag_in[0], {QW{1'b0}}};
            neg_reg[0] <= neg_in;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar j = 1; j < DIV_ST; j++) begin : g_step
        logic [DIVW-1:0] dsh;
        logic [DIVW-1:0] remx;
        logic [DIVW-1:0] diff;
        logic            ge;
        logic [QW-1:0]   q_next;

        assign dsh  = {{QW{1'b0}}, mag_in[j]} << (QW - j);
        assign remx = {{(DIVW-NUMW){1'b0}}, rem_reg[j-1]};
        assign ge   = remx >= dsh;
        assign diff = remx - dsh;

        always_comb begin
            q_next = q_reg[j-1];
            q_next[QW-j] = ge;
        end

        always_ff @(posedge clk) begin
            if (en[j]) begin
                rem_reg[j] <= ge ? diff[NUMW-1:0] : rem_reg[j-1];
                q_reg[j]   <= q_next;
                big_reg[j] <= big_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
            end
        end
    end

    assign q   = q_reg[DIV_ST-1];
    assign big = big_reg[DIV_ST-1];
    assign neg = neg_reg[DIV_ST-1];
endmodule

/* design/mtx_inv_merge.sv */
module mtx_inv_merge (
    input  logic                               clk,
    input  logic                               en,
    input  logic [mtx_inv_pkg::QW-1:0]         q   [mtx_inv_pkg::NL],
    input  logic                               big [mtx_inv_pkg::NL],
    input  logic                               neg [mtx_inv_pkg::NL],
    input  logic                               sing,
    output logic signed [mtx_inv_pkg::DW-1:0]  b   [mtx_inv_pkg::NL],
    output logic                               invertible
);
    import mtx_inv_pkg::*;

    localparam logic [QW-1:0] LIM_POS = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] LIM_NEG = {1'b1, {(QW-1){1'b0}}};

    for (genvar k = 0; k < NL; k++) begin : g_sat
        logic [QW-1:0] lim;
        logic [QW-1:0] qs;
        assign lim = neg[k] ? LIM_NEG : LIM_POS;
        assign qs  = (big[k] || (q[k] > lim)) ? lim : q[k];
        always_ff @(posedge clk) begin
            if (en) begin
                b[k] <= sing ? '0 : (neg[k] ? $signed(~qs + 1'b1) : $signed(qs));
            end
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            invertible <= !sing;
        end
    end
endmodule

/* design/matrix3x3_inverse_top.sv */
// throughput: one matrix per cycle unless the output stalls, set by the 33-stage pipelined divider per lane
// stalls ripple back only into full stages, bubbles are squeezed out
// reset: pipeline emptied and singular_threshold cleared to zero
module matrix3x3_inverse_top (
    input  logic                              clk,
    input  logic                              rst_n,
    mtx_inv_in_if.sink                        mat_in,
    mtx_inv_out_if.source                     inv_out,
    input  logic                              cfg_we,
    input  logic [mtx_inv_pkg::THR_W-1:0]     cfg_wdata
);
    import mtx_inv_pkg::*;

    logic [NSTG-1:0]       v_reg;
    logic [NSTG-1:0]       rdy;
    logic [NSTG-1:0]       en;
    logic [NSTG-1:0]       vin;
    logic [THR_W-1:0]      thr_reg;
    logic signed [DW-1:0]  a [NL];
    logic [MAGW-1:0]       mag5;
    logic                  sing5;
    logic [NUMW-1:0]       num5 [NL];
    logic                  neg5 [NL];
    logic [MAGW-1:0]       magp_reg [DIV_ST-1];
    logic                  sing_reg [DIV_ST];
    logic [MAGW-1:0]       mag_in [DIV_ST];
    logic [QW-1:0]         lq [NL];
    logic                  lbig [NL];
    logic                  lneg [NL];
    logic signed [DW-1:0]  b [NL];
    logic                  inv;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    // a stage moves when it or any later stage has a hole or the sink takes
    assign vin = {v_reg[NSTG-2:0], mat_in.valid};
    always_comb begin
        for (int i = 0; i < NSTG; i++) begin
            rdy[i] = inv_out.ready || (|(~v_reg & ({NSTG{1'b1}} << i)));
        end
    end
    assign en = rdy & vin;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NSTG; i++) begin
                if (rdy[i])
                begin
                    v_reg[i] <= vin[i];
                end
            end
        end
    end

    assign mat_in.ready = rdy[0];

    assign a[0] = mat_in.a00;
    assign a[1] = mat_in.a01;
    assign a[2] = mat_in.a02;
    assign a[3] = mat_in.a10;
    assign a[4] = mat_in.a11;
    assign a[5] = mat_in.a12;
    assign a[6] = mat_in.a20;
    assign a[7] = mat_in.a21;
    assign a[8] = mat_in.a22;

    mtx_inv_front u_front (
        .clk  (clk),
        .en   (en[FRONT_ST-1:0]),
        .a    (a),
        .thr  (thr_reg),
        .mag  (mag5),
        .sing (sing5),
        .num  (num5),
        .neg  (neg5)
    );

    // determinant magnitude and singular flag travel beside the lanes
    assign mag_in[0] = mag5;
    for (genvar j = 1; j < DIV_ST; j++) begin : g_magin
        assign mag_in[j] = magp_reg[j-1];
    end

    for (genvar j = 0; j < DIV_ST; j++) begin : g_side
        always_ff @(posedge clk) begin
            if (en[FRONT_ST+j]) begin
                sing_reg[j] <= (j == 0) ? sing5 : sing_reg[(j == 0) ? 0 : j-1];
            end
        end
        if (j < DIV_ST - 1) begin : g_mag
            always_ff @(posedge clk) begin
                if (en[FRONT_ST+j]) begin
                    magp_reg[j] <= mag_in[j];
                end
            end
        end
    end

    for (genvar k = 0; k < NL; k++) begin : g_lane
        mtx_inv_div_lane u_lane (
            .clk    (clk),
            .en     (en[FRONT_ST+DIV_ST-1:FRONT_ST]),
            .num_in (num5[k]),
            .neg_in (neg5[k]),
            .mag_in (mag_in),
            .q      (lq[k]),
            .big    (lbig[k]),
            .neg    (lneg[k])
        );
    end

    mtx_inv_merge u_merge (
        .clk        (clk),
        .en         (en[NSTG-1]),
        .q          (lq),
        .big        (lbig),
        .neg        (lneg),
        .sing       (sing_reg[DIV_ST-1]),
        .b          (b),
        .invertible (inv)
    );

    assign inv_out.valid      = v_reg[NSTG-1];
    assign inv_out.b00        = b[0];
    assign inv_out.b01        = b[1];
    assign inv_out.b02        = b[2];
    assign inv_out.b10        = b[3];
    assign inv_out.b11        = b[4];
    assign inv_out.b12        = b[5];
    assign inv_out.b20        = b[6];
    assign inv_out.b21        = b[7];
    assign inv_out.b22        = b[8];
    assign inv_out.invertible = inv;

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (mat_in.valid && mat_in.ready) |=> v_reg[0])
        else $error("accepted transaction not captured");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !mat_in.ready |-> (&v_reg))
        else $error("input stalled with a free stage");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (inv_out.valid && !inv_out.invertible) |->
        (inv_out.b00 == 0 && inv_out.b11 == 0 && inv_out.b22 == 0 && inv_out.b01 == 0))
        else $error("singular result carries nonzero entries");
endmodule
